### sv/i2cmbe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// shared types and constants of the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    localparam int DELAY_COUNTER_WIDTH_DEF = 16;
    localparam int TICK_W                  = 10;
    localparam logic [TICK_W-1:0] TICK_RESET = 10'd50;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_START    = 3'd1,
        KIND_STOP     = 3'd2,
        KIND_SEND     = 3'd3,
        KIND_WAIT_ACK = 3'd4,
        KIND_READ     = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST_A = 4'd1,
        PH_ST_B = 4'd2,
        PH_SP_A = 4'd3,
        PH_SP_B = 4'd4,
        PH_WA_A = 4'd5,
        PH_TX_D = 4'd6,
        PH_TX_H = 4'd7,
        PH_TX_L = 4'd8,
        PH_RX_L = 4'd9,
        PH_RX_H = 4'd10,
        PH_AK_A = 4'd11,
        PH_AK_B = 4'd12
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       ack_failed;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

### sv/i2cmbe_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_in_stage
// input register of the engine, holds one item until the sequencer takes it
// ----------------------------------------------------------------------------
module i2cmbe_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cmbe_pkg::item_t   in_item,
    input  logic                advance,
    output logic                item_valid,
    output i2cmbe_pkg::item_t   item
);
    import i2cmbe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/i2cmbe_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_seq
// line sequencer: phase state machine, delay counter, shift and bit counters
// ----------------------------------------------------------------------------
module i2cmbe_seq #(
    parameter int DELAY_COUNTER_WIDTH = i2cmbe_pkg::DELAY_COUNTER_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  i2cmbe_pkg::item_t               item,
    input  logic [i2cmbe_pkg::TICK_W-1:0]   ticks_per_us,
    output i2cmbe_pkg::result_t             result
);
    import i2cmbe_pkg::*;

    localparam int DW = DELAY_COUNTER_WIDTH;
    localparam int LW = TICK_W + 2;
    localparam int PW = (DW > LW) ? DW : LW;

    phase_t        phase_reg, phase_next;
    logic [3:0]    bit_reg, bit_next;
    logic [7:0]    shift_reg, shift_next;
    logic [DW-1:0] delay_reg, delay_next;
    logic          scl_reg, scl_next;
    logic          sda_reg, sda_next;
    logic          sda_en_reg, sda_en_next;
    logic          ack_reg, ack_next;
    logic          nack_reg, nack_next;
    logic [7:0]    read_reg, read_next;
    logic          done_next;

    logic [TICK_W-1:0] tick_eff;
    logic [DW-1:0]     dly1, dly2, dly4;
    logic              go;
    phase_t            target;

    function automatic logic [DW-1:0] sat_delay(input logic [LW-1:0] v);
        logic [PW-1:0] ext;
        ext = PW'(v);
        return (|(ext >> DW)) ? {DW{1'b1}} : ext[DW-1:0];
    endfunction

    assign tick_eff = (ticks_per_us == '0) ? TICK_W'(1) : ticks_per_us;
    assign dly1     = sat_delay({2'b00, tick_eff});
    assign dly2     = sat_delay({1'b0, tick_eff, 1'b0});
    assign dly4     = sat_delay({tick_eff, 2'b00});

    always_comb begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        delay_next  = delay_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        sda_en_next = sda_en_reg;
        ack_next    = ack_reg;
        nack_next   = nack_reg;
        read_next   = read_reg;
        done_next   = 1'b0;
        go          = 1'b0;
        target      = PH_IDLE;

        if (phase_reg == PH_IDLE) begin
            case (kind_t'(item.kind))
                KIND_START: begin
                    go     = 1'b1;
                    target = PH_ST_A;
                end
                KIND_STOP: begin
                    go     = 1'b1;
                    target = PH_SP_A;
                end
                KIND_SEND: begin
                    sda_en_next = 1'b1;
                    scl_next    = 1'b0;
                    shift_next  = item.write_data;
                    bit_next    = '0;
                    go          = 1'b1;
                    target      = PH_TX_D;
                end
                KIND_WAIT_ACK: begin
                    go     = 1'b1;
                    target = PH_WA_A;
                end
                KIND_READ: begin
                    sda_en_next = 1'b0;
                    shift_next  = '0;
                    bit_next    = '0;
                    ack_next    = item.send_ack;
                    go          = 1'b1;
                    target      = PH_RX_L;
                end
                default: begin
                end
            endcase
        end else if (delay_reg > DW'(1)) begin
            delay_next = delay_reg - DW'(1);
        end else begin
            delay_next = '0;
            case (phase_reg)
                PH_ST_A: begin
                    go     = 1'b1;
                    target = PH_ST_B;
                end
                PH_ST_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_SP_A: begin
                    go     = 1'b1;
                    target = PH_SP_B;
                end
                PH_SP_B: begin
                    sda_en_next = 1'b1;
                    phase_next  = PH_IDLE;
                    done_next   = 1'b1;
                end
                PH_WA_A: begin
                    if (item.sda_in) begin
                        nack_next = 1'b1;
                        go        = 1'b1;
                        target    = PH_SP_A;
                    end else begin
                        nack_next   = 1'b0;
                        scl_next    = 1'b0;
                        sda_en_next = 1'b1;
                        phase_next  = PH_IDLE;
                        done_next   = 1'b1;
                    end
                end
                PH_TX_D: begin
                    go     = 1'b1;
                    target = PH_TX_H;
                end
                PH_TX_H: begin
                    go     = 1'b1;
                    target = PH_TX_L;
                end
                PH_TX_L: begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_next[3]) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        go     = 1'b1;
                        target = PH_TX_D;
                    end
                end
                PH_RX_L: begin
                    go     = 1'b1;
                    target = PH_RX_H;
                end
                PH_RX_H: begin
                    bit_next = bit_reg + 4'd1;
                    go       = 1'b1;
                    if (bit_next[3]) begin
                        read_next = shift_reg;
                        target    = PH_AK_A;
                    end else begin
                        target = PH_RX_L;
                    end
                end
                PH_AK_A: begin
                    go     = 1'b1;
                    target = PH_AK_B;
                end
                PH_AK_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // entry actions of the next phase
        if (go) begin
            phase_next = target;
            case (target)
                PH_ST_A: begin
                    sda_en_next = 1'b1;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                    delay_next  = dly4;
                end
                PH_ST_B: begin
                    sda_next   = 1'b0;
                    delay_next = dly4;
                end
                PH_SP_A: begin
                    sda_en_next = 1'b1;
                    sda_next    = 1'b0;
                    scl_next    = 1'b0;
                    delay_next  = dly4;
                end
                PH_SP_B: begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    delay_next = dly4;
                end
                PH_WA_A: begin
                    sda_en_next = 1'b0;
                    scl_next    = 1'b1;
                    delay_next  = dly1;
                end
                PH_TX_D: begin
                    sda_next   = shift_next[7];
                    shift_next = {shift_next[6:0], 1'b0};
                    delay_next = dly2;
                end
                PH_TX_H: begin
                    scl_next   = 1'b1;
                    delay_next = dly2;
                end
                PH_TX_L: begin
                    scl_next   = 1'b0;
                    delay_next = dly2;
                end
                PH_RX_L: begin
                    scl_next   = 1'b0;
                    delay_next = dly2;
                end
                PH_RX_H: begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], item.sda_in};
                    delay_next = dly2;
                end
                PH_AK_A: begin
                    sda_en_next = 1'b1;
                    scl_next    = 1'b0;
                    sda_next    = ~ack_next;
                    delay_next  = dly2;
                end
                PH_AK_B: begin
                    scl_next   = 1'b1;
                    delay_next = dly2;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            bit_reg    <= '0;
            shift_reg  <= '0;
            delay_reg  <= '0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            sda_en_reg <= 1'b1;
            ack_reg    <= 1'b0;
            nack_reg   <= 1'b0;
            read_reg   <= '0;
        end else if (step) begin
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            delay_reg  <= delay_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            sda_en_reg <= sda_en_next;
            ack_reg    <= ack_next;
            nack_reg   <= nack_next;
            read_reg   <= read_next;
        end
    end

    always_comb begin
        result.scl_level  = scl_next;
        result.sda_level  = sda_next;
        result.sda_drive  = sda_en_next;
        result.busy_res   = (phase_next != PH_IDLE);
        result.done_res   = done_next;
        result.read_data  = read_next;
        result.ack_failed = nack_next;
    end

endmodule

### sv/i2cmbe_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbe_out_stage
// result register, holds a finished result until the downstream takes it
// ----------------------------------------------------------------------------
module i2cmbe_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  i2cmbe_pkg::result_t   result_in,
    input  logic                  out_ready,
    output logic                  out_valid,
    output i2cmbe_pkg::result_t   result_out,
    output logic                  can_load
);
    import i2cmbe_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

### sv/i2c_master_bit_engine.sv
`timescale 1ns / 1ps
// result path: each input transaction passes the input reg, then the result reg
// throughput: one transaction per cycle, limited only by m_tready backpressure
// the sequencer advances one tick per item taken from the input register
// reset (aresetn low, synchronous): pipeline empty, sequencer idle, scl/sda high
// and driven, tick count 50
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// i2c master line engine, one stream transaction per line timing tick
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
    parameter int DELAY_COUNTER_WIDTH = i2cmbe_pkg::DELAY_COUNTER_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [i2cmbe_pkg::TICK_W-1:0]   cfg_wdata,   // ticks_per_microsecond
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,     // write_data, send_ack, sda_in
    input  logic [2:0]                      s_tuser,     // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // scl_level, sda_level, sda_drive, busy_res, done_res, read_data, ack_failed
    output logic [15:0]                     m_tdata
);
    import i2cmbe_pkg::*;

    logic [TICK_W-1:0] tick_reg;
    item_t             in_item;
    item_t             item;
    logic              item_valid;
    logic              can_load;
    logic              advance;
    result_t           result;
    result_t           result_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= TICK_RESET;
        end else if (cfg_we) begin
            tick_reg <= cfg_wdata;
        end
    end

    always_comb begin
        in_item.kind       = s_tuser;
        in_item.write_data = s_tdata[7:0];
        in_item.send_ack   = s_tdata[8];
        in_item.sda_in     = s_tdata[9];
    end

    assign advance = item_valid && can_load;

    i2cmbe_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cmbe_seq #(
        .DELAY_COUNTER_WIDTH (DELAY_COUNTER_WIDTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .item         (item),
        .ticks_per_us (tick_reg),
        .result       (result)
    );

    i2cmbe_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .result_in  (result),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .result_out (result_out),
        .can_load   (can_load)
    );

    assign m_tdata = {2'b00, result_out};

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result_out.done_res && result_out.busy_res))
        else $error("done and busy set in the same result");

    a_item_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !m_tvalid) |=> m_tvalid)
        else $error("held item not moved to empty result register");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && result.done_res) |-> $past(aresetn) && u_seq.phase_reg != PH_IDLE)
        else $error("done pulse without a running sequence");

endmodule

### dv/i2c_master_bit_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_test
// self-checking bench for the i2c master line engine. a queue of line ticks
// (commands plus sampled sda) feeds a stream driver; each accepted tick is run
// through a cycle model of the engine and the predicted line state is checked
// field by field against the returned transaction. the tick count register is
// swept over its reset value, zero and a small value.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_test;
    import i2cmbe_pkg::*;

    localparam int CYCLE_LIMIT = 300_000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [TICK_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [15:0]       s_tdata;     // write_data, send_ack, sda_in
    logic [2:0]        s_tuser;     // kind
    logic              m_tvalid;
    logic              m_tready;
    // scl_level, sda_level, sda_drive, busy_res, done_res, read_data, ack_failed
    logic [15:0]       m_tdata;

    i2c_master_bit_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    item_t   tick_q[$];
    result_t line_q[$];
    item_t   drv_item;
    logic    s_taken;
    int      send_idle;
    int      recv_idle;
    int      n_queued;
    int      n_checked;
    int      fail_cnt;
    int      cycle_cnt;
    int      gen_tick;

    // engine model state
    logic [TICK_W-1:0]                  tick_cfg;
    phase_t                             ph;
    logic [3:0]                         bit_cnt;
    logic [7:0]                         shreg;
    logic [DELAY_COUNTER_WIDTH_DEF-1:0] dly_cnt;
    logic                               scl_q;
    logic                               sda_q;
    logic                               sda_en;
    logic                               ack_ans;
    logic                               nack_q;
    logic [7:0]                         rd_byte;
    logic                               done_q;

    task automatic reset_engine();
        tick_cfg = TICK_RESET;
        ph       = PH_IDLE;
        bit_cnt  = '0;
        shreg    = '0;
        dly_cnt  = '0;
        scl_q    = 1'b1;
        sda_q    = 1'b1;
        sda_en   = 1'b1;
        ack_ans  = 1'b0;
        nack_q   = 1'b0;
        rd_byte  = '0;
        done_q   = 1'b0;
    endtask

    task automatic load_units(input int units);
        longint t;
        longint v;
        longint cap;
        t   = (tick_cfg == 0) ? 1 : tick_cfg;
        cap = (longint'(1) << DELAY_COUNTER_WIDTH_DEF) - 1;
        v   = units * t;
        if (v > cap) v = cap;
        dly_cnt = v[DELAY_COUNTER_WIDTH_DEF-1:0];
    endtask

    task automatic enter_phase(input phase_t p, input logic sda);
        ph = p;
        case (p)
            PH_ST_A: begin
                sda_en = 1'b1; sda_q = 1'b1; scl_q = 1'b1; load_units(4);
            end
            PH_ST_B: begin
                sda_q = 1'b0; load_units(4);
            end
            PH_SP_A: begin
                sda_en = 1'b1; sda_q = 1'b0; scl_q = 1'b0; load_units(4);
            end
            PH_SP_B: begin
                sda_q = 1'b1; scl_q = 1'b1; load_units(4);
            end
            PH_WA_A: begin
                sda_en = 1'b0; scl_q = 1'b1; load_units(1);
            end
            PH_TX_D: begin
                sda_q = shreg[7];
                shreg = {shreg[6:0], 1'b0};
                load_units(2);
            end
            PH_TX_H, PH_AK_B: begin
                scl_q = 1'b1; load_units(2);
            end
            PH_TX_L, PH_RX_L: begin
                scl_q = 1'b0; load_units(2);
            end
            PH_RX_H: begin
                scl_q = 1'b1;
                shreg = {shreg[6:0], sda};
                load_units(2);
            end
            PH_AK_A: begin
                sda_en = 1'b1; scl_q = 1'b0; sda_q = ~ack_ans; load_units(2);
            end
            default: ph = PH_IDLE;
        endcase
    endtask

    task automatic expire_phase(input logic sda);
        case (ph)
            PH_ST_A: enter_phase(PH_ST_B, sda);
            PH_ST_B: begin
                scl_q = 1'b0; ph = PH_IDLE; done_q = 1'b1;
            end
            PH_SP_A: enter_phase(PH_SP_B, sda);
            PH_SP_B: begin
                sda_en = 1'b1; ph = PH_IDLE; done_q = 1'b1;
            end
            PH_WA_A: begin
                if (sda) begin
                    nack_q = 1'b1;
                    enter_phase(PH_SP_A, sda);
                end else begin
                    nack_q = 1'b0; scl_q = 1'b0; sda_en = 1'b1;
                    ph = PH_IDLE; done_q = 1'b1;
                end
            end
            PH_TX_D: enter_phase(PH_TX_H, sda);
            PH_TX_H: enter_phase(PH_TX_L, sda);
            PH_TX_L: begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt >= 8) begin
                    ph = PH_IDLE; done_q = 1'b1;
                end else begin
                    enter_phase(PH_TX_D, sda);
                end
            end
            PH_RX_L: enter_phase(PH_RX_H, sda);
            PH_RX_H: begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt >= 8) begin
                    rd_byte = shreg;
                    enter_phase(PH_AK_A, sda);
                end else begin
                    enter_phase(PH_RX_L, sda);
                end
            end
            PH_AK_A: enter_phase(PH_AK_B, sda);
            PH_AK_B: begin
                scl_q = 1'b0; ph = PH_IDLE; done_q = 1'b1;
            end
            default: ph = PH_IDLE;
        endcase
    endtask

    task automatic advance_engine(input item_t it, output result_t r);
        done_q = 1'b0;
        if (ph == PH_IDLE) begin
            case (it.kind)
                KIND_START: enter_phase(PH_ST_A, it.sda_in);
                KIND_STOP:  enter_phase(PH_SP_A, it.sda_in);
                KIND_SEND: begin
                    sda_en = 1'b1; scl_q = 1'b0;
                    shreg = it.write_data; bit_cnt = '0;
                    enter_phase(PH_TX_D, it.sda_in);
                end
                KIND_WAIT_ACK: enter_phase(PH_WA_A, it.sda_in);
                KIND_READ: begin
                    sda_en = 1'b0; shreg = '0; bit_cnt = '0;
                    ack_ans = it.send_ack;
                    enter_phase(PH_RX_L, it.sda_in);
                end
                default: ;
            endcase
        end else if (dly_cnt > 1) begin
            dly_cnt = dly_cnt - 1'b1;
        end else begin
            dly_cnt = '0;
            expire_phase(it.sda_in);
        end
        r.scl_level  = scl_q;
        r.sda_level  = sda_q;
        r.sda_drive  = sda_en;
        r.busy_res   = (ph != PH_IDLE);
        r.done_res   = done_q;
        r.read_data  = rd_byte;
        r.ack_failed = nack_q;
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // stimulus side

    task automatic queue_tick(input logic [2:0] kind, input logic [7:0] wd,
                              input logic sack, input logic sda);
        item_t it;
        it.kind       = kind;
        it.write_data = wd;
        it.send_ack   = sack;
        it.sda_in     = sda;
        tick_q.push_back(it);
        n_queued++;
    endtask

    // one command followed by the ticks it keeps the engine busy, plus slack;
    // line_bits gives the sda level at wait-ack sampling or the byte a read sees
    task automatic queue_cmd(input logic [2:0] kind, input logic [7:0] wd, input logic sack,
                             input logic [7:0] line_bits, input int slack, input bit noisy);
        int u;
        int span;
        int k;
        int slot;
        logic sda;
        logic [2:0] fk;
        u = (gen_tick == 0) ? 1 : gen_tick;
        case (kind)
            KIND_START, KIND_STOP: span = 8 * u;
            KIND_SEND:             span = 48 * u;
            KIND_WAIT_ACK:         span = line_bits[0] ? 9 * u : u;
            KIND_READ:             span = 36 * u;
            default:               span = 0;
        endcase
        queue_tick(kind, wd, sack, 1'($urandom_range(1)));
        for (k = 1; k <= span + slack; k++) begin
            sda  = 1'($urandom_range(1));
            fk   = KIND_NONE;
            slot = k - 2 * u;
            if (kind == KIND_WAIT_ACK && k == u) sda = line_bits[0];
            if (kind == KIND_READ && slot >= 0 && slot % (4 * u) == 0 && slot / (4 * u) < 8)
                sda = line_bits[7 - slot / (4 * u)];
            if (noisy && k <= span && $urandom_range(7) == 0) fk = 3'($urandom_range(7));
            queue_tick(fk, 8'($urandom_range(255)), 1'($urandom_range(1)), sda);
        end
    endtask

    task automatic queue_transfer();
        int n_ops;
        int j;
        bit noisy;
        bit nack;
        noisy = $urandom_range(1);
        nack  = ($urandom_range(4) == 0);
        queue_cmd(KIND_START, 0, 0, 0, $urandom_range(2), noisy);
        queue_cmd(KIND_SEND, 8'($urandom_range(255)), 0, 0, $urandom_range(2), noisy);
        queue_cmd(KIND_WAIT_ACK, 0, 0, {7'b0, nack}, $urandom_range(2), noisy);
        if (!nack) begin
            n_ops = $urandom_range(2);
            for (j = 0; j < n_ops; j++) begin
                if ($urandom_range(1)) begin
                    queue_cmd(KIND_SEND, 8'($urandom_range(255)), 0, 0,
                              $urandom_range(2), noisy);
                    queue_cmd(KIND_WAIT_ACK, 0, 0, 0, $urandom_range(2), noisy);
                end else begin
                    queue_cmd(KIND_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                              8'($urandom_range(255)), $urandom_range(2), noisy);
                end
            end
            queue_cmd(KIND_STOP, 0, 0, 0, $urandom_range(2), noisy);
        end
    endtask

    task automatic queue_random(input int n_items);
        int first;
        first = n_queued;
        while (n_queued - first < n_items) begin
            if ($urandom_range(99) < 75) begin
                queue_transfer();
            end else begin
                queue_cmd(3'($urandom_range(7)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 8'($urandom_range(255)),
                          int'($urandom_range(3)) - 1, 1);
            end
        end
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued) @(posedge aclk);
    endtask

    task automatic write_tick(input logic [TICK_W-1:0] v);
        @(negedge aclk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        gen_tick = v;
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if (!s_tvalid || s_taken) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    drv_item = tick_q.pop_front();
                    s_tuser  <= drv_item.kind;
                    s_tdata  <= {6'b0, drv_item.sda_in, drv_item.send_ack,
                                 drv_item.write_data};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and model
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        result_t res;
        if (!aresetn) begin
            reset_engine();
            line_q.delete();
        end else begin
            if (cfg_we) tick_cfg = cfg_wdata;
            if (m_tvalid && m_tready) begin
                n_checked <= n_checked + 1;
                got = result_t'(m_tdata[13:0]);
                if (line_q.size() == 0) begin
                    $error("unexpected transaction, m_tdata %h", m_tdata);
                    fail_cnt++;
                end else begin
                    want = line_q.pop_front();
                    check_field("scl_level", want.scl_level, got.scl_level);
                    check_field("sda_level", want.sda_level, got.sda_level);
                    check_field("sda_drive", want.sda_drive, got.sda_drive);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("ack_failed", want.ack_failed, got.ack_failed);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_engine(item_t'({s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[9]}), res);
                line_q.push_back(res);
            end
        end
        s_taken <= aresetn && s_tvalid && s_tready;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        s_taken   = 1'b0;
        n_queued  = 0;
        n_checked = 0;
        fail_cnt  = 0;
        cycle_cnt = 0;
        gen_tick  = TICK_RESET;
        send_idle = 38;
        recv_idle = 62;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset tick count
        queue_cmd(KIND_WAIT_ACK, 0, 0, 8'h00, 0, 0);
        wait_drained();

        // zero tick count acts as one
        write_tick(0);
        queue_cmd(KIND_START, 0, 0, 0, 0, 0);
        queue_cmd(KIND_SEND, 8'hff, 0, 0, 1, 0);
        queue_cmd(KIND_WAIT_ACK, 0, 0, 8'h00, 0, 0);
        queue_cmd(KIND_READ, 8'h00, 1, 8'hff, 0, 0);
        // nack runs the stop sequence on its own
        queue_cmd(KIND_WAIT_ACK, 0, 0, 8'h01, 0, 0);
        queue_cmd(3'd6, 8'h5a, 1, 0, 0, 0);
        queue_cmd(3'd7, 8'ha5, 0, 0, 0, 0);
        // command on the finishing tick is dropped
        queue_cmd(KIND_STOP, 0, 0, 0, -1, 0);
        queue_cmd(KIND_START, 0, 0, 0, 0, 0);
        queue_cmd(KIND_STOP, 0, 0, 0, 2, 1);
        wait_drained();

        write_tick(1);
        queue_random(30);
        wait_drained();

        send_idle = 62;
        recv_idle = 38;
        queue_random(30);
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        queue_random(30);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (line_q.size() != 0) begin
            $error("%0d transactions never returned", line_q.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
